// File: sv/block_cache_lru_clean_first_assert.svh
// Assertion macros for the cache directory RTL.
`ifndef BLOCK_CACHE_LRU_CLEAN_FIRST_ASSERT_SVH
`define BLOCK_CACHE_LRU_CLEAN_FIRST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication on clk, disabled during rst.
`define BCLF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bclf: same-cycle check failed");

// Next-cycle implication on clk, disabled during rst.
`define BCLF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bclf: next-cycle check failed");

`else

`define BCLF_ASSERT_IMP(label, ante, cons)
`define BCLF_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: sv/bclf_pkg.sv
// Types and constants shared by the cache directory cells and the controller.
`default_nettype none

package bclf_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int FLUSH_W   = $clog2(SLOTS + 1);
  localparam int TAG_W     = 32;
  localparam int AGE_W     = 64;
  localparam int CNT_W     = 32;
  localparam int SPB_W     = 8;
  localparam int LBA_W     = 39;
  localparam int SLOT_OUT_W  = 4;
  localparam int FLUSH_OUT_W = 5;
  localparam int KIND_W    = 3;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 112;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUNTED     = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET  = 2'd0,
    REQ_MARK = 2'd1,
    REQ_SYNC = 2'd2,
    REQ_BAD  = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    K_HIT   = 3'd0,
    K_WB    = 3'd1,
    K_FILL  = 3'd2,
    K_FFAIL = 3'd3,
    K_REJ   = 3'd4,
    K_DSET  = 3'd5,
    K_NC    = 3'd6,
    K_SYNC  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILL,
    OP_TOUCH,
    OP_SET_DIRTY,
    OP_CLR_DIRTY
  } cell_op_t;

  // Update broadcast from the controller to all cells; only cell idx acts.
  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] idx;
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
  } cell_cmd_t;

  // Running lookup and victim choice handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] hit_idx;
    logic              have;
    logic [SLOT_W-1:0] best_idx;
    logic              best_dirty;
    logic [AGE_W-1:0]  best_age;
    logic [TAG_W-1:0]  best_tag;
  } chain_t;

  // Per-cell status seen by the controller.
  typedef struct packed {
    logic             match;
    logic             flush;
    logic [TAG_W-1:0] tag;
  } cell_stat_t;

endpackage

`default_nettype wire

// File: sv/block_cache_lru_clean_first.sv
// Top level: fully associative write-back cache directory with clean-first LRU.
//
//  Channel  Signals                              Contents (low bit first)
//  request  s_tvalid s_tready s_tdata s_tuser    tdata: block_number, fill_fails; tuser: req_type
//  result   m_tvalid m_tready m_tdata m_tuser    tdata: slot, lba, flushed_count, device_reads,
//           m_tlast                                     device_writes; tuser: kind; tlast: last
//  config   cfg_we cfg_index cfg_data            0 block_count, 1 sectors_per_block, 2 mounted
//
// One request at a time. Every request first runs the 16-cell search chain: accept (S_IDLE),
// let the chain settle (S_SCAN), then decide (S_DECIDE). A miss adds an LBA multiply and
// the fill result, preceded by a multiply and a writeback result when the victim is dirty;
// a mounted sync finds, multiplies and writes back each dirty slot, then gives its result.
// The next request is taken while the last result still sits in the output register;
// a stalled result holds the controller only when it has another result to give.
// rst is synchronous: all slots empty and clean, counters zero, no result pending.
`default_nettype none
`include "block_cache_lru_clean_first_assert.svh"

module block_cache_lru_clean_first (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bclf_pkg::IN_DATA_W-1:0]    s_tdata,   // block_number[31:0], fill_fails[32]
  input  logic [bclf_pkg::REQ_W-1:0]        s_tuser,   // req_type[1:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bclf_pkg::OUT_DATA_W-1:0]   m_tdata,   // slot, lba, flushed_count, reads, writes
  output logic [bclf_pkg::KIND_W-1:0]       m_tuser,   // kind[2:0]
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [bclf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bclf_pkg::CFG_W-1:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MUL_WB,
    S_EMIT_WB,
    S_MUL_FILL,
    S_EMIT_FILL,
    S_SYNC_FIND,
    S_MUL_SWB,
    S_EMIT_SWB
  } state_t;

  state_t                            state;
  bclf_pkg::req_t                    req_q;
  logic [bclf_pkg::TAG_W-1:0]        blk_q;
  logic                              fail_q;
  logic [bclf_pkg::SLOT_W-1:0]       cnt;
  logic [bclf_pkg::SLOT_W-1:0]       vidx;
  logic [bclf_pkg::TAG_W-1:0]        vtag;
  logic [bclf_pkg::LBA_W-1:0]        lba_q;
  logic [bclf_pkg::FLUSH_W-1:0]      flushed;
  logic [bclf_pkg::AGE_W-1:0]        age_clock;
  logic [bclf_pkg::CNT_W-1:0]        rd_cnt;
  logic [bclf_pkg::CNT_W-1:0]        wr_cnt;

  logic [bclf_pkg::TAG_W-1:0]        block_count;
  logic [bclf_pkg::SPB_W-1:0]        spb;
  logic                              mounted;

  logic                              out_valid;
  bclf_pkg::kind_t                   out_kind;
  logic [bclf_pkg::SLOT_OUT_W-1:0]   out_slot;
  logic [bclf_pkg::LBA_W-1:0]        out_lba;
  logic [bclf_pkg::FLUSH_OUT_W-1:0]  out_flushed;
  logic [bclf_pkg::CNT_W-1:0]        out_reads;
  logic [bclf_pkg::CNT_W-1:0]        out_writes;
  logic                              out_last;

  bclf_pkg::chain_t                  chain [bclf_pkg::SLOTS];
  bclf_pkg::chain_t                  chain_seed;
  bclf_pkg::chain_t                  chain_end;
  bclf_pkg::cell_stat_t              stat  [bclf_pkg::SLOTS];
  bclf_pkg::cell_cmd_t               cmd;

  logic [bclf_pkg::SLOTS-1:0]        match_vec;
  logic [bclf_pkg::SLOTS-1:0]        pend_vec;
  logic [bclf_pkg::SLOT_W-1:0]       first;
  logic                              any_pend;
  logic                              reject;
  logic                              out_free;
  logic [bclf_pkg::TAG_W-1:0]        mul_a;
  logic [bclf_pkg::TAG_W+bclf_pkg::SPB_W-1:0] mul_full;
  logic [bclf_pkg::AGE_W-1:0]        age_inc;

  logic                              emit;
  logic                              age_step;
  bclf_pkg::kind_t                   e_kind;
  logic [bclf_pkg::SLOT_W-1:0]       e_slot;
  logic [bclf_pkg::LBA_W-1:0]        e_lba;
  logic [bclf_pkg::FLUSH_W-1:0]      e_flushed;
  logic [bclf_pkg::CNT_W-1:0]        e_reads;
  logic [bclf_pkg::CNT_W-1:0]        e_writes;
  logic                              e_last;

  // Search chain: each cell folds its slot into the running result and passes it on.
  assign chain_seed = '0;

  for (genvar g = 0; g < bclf_pkg::SLOTS; g++) begin : g_cell
    bclf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (bclf_pkg::SLOT_W'(g)),
      .blk       (blk_q),
      .cmd       (cmd),
      .chain_in  ((g == 0) ? chain_seed : chain[(g == 0) ? 0 : g - 1]),
      .chain_out (chain[g]),
      .stat      (stat[g])
    );
    assign match_vec[g] = stat[g].match;
    assign pend_vec[g]  = stat[g].flush;
  end

  assign chain_end = chain[bclf_pkg::SLOTS-1];

  always_comb begin
    first    = '0;
    any_pend = 1'b0;
    for (int i = bclf_pkg::SLOTS - 1; i >= 0; i--) begin
      if (pend_vec[i]) begin
        first    = bclf_pkg::SLOT_W'(i);
        any_pend = 1'b1;
      end
    end
  end

  assign reject   = (blk_q == '0) || (blk_q >= block_count);
  assign out_free = !out_valid || m_tready;
  assign mul_a    = (state == S_MUL_FILL) ? blk_q : vtag;
  assign mul_full = {{bclf_pkg::SPB_W{1'b0}}, mul_a} * {{bclf_pkg::TAG_W{1'b0}}, spb};
  assign age_inc  = age_clock + bclf_pkg::AGE_W'(1);

  // Result selection and cell update for the current step.
  always_comb begin
    emit      = 1'b0;
    age_step  = 1'b0;
    e_kind    = bclf_pkg::K_REJ;
    e_slot    = '0;
    e_lba     = '0;
    e_flushed = '0;
    e_reads   = rd_cnt;
    e_writes  = wr_cnt;
    e_last    = 1'b1;
    cmd.op    = bclf_pkg::OP_NONE;
    cmd.idx   = vidx;
    cmd.tag   = blk_q;
    cmd.age   = age_inc;

    unique case (state)
      S_DECIDE: begin
        unique case (req_q)
          bclf_pkg::REQ_GET: begin
            if (reject) begin
              emit = out_free;
            end else if (chain_end.found) begin
              emit     = out_free;
              age_step = out_free;
              e_kind   = bclf_pkg::K_HIT;
              e_slot   = chain_end.hit_idx;
              if (out_free) begin
                cmd.op  = bclf_pkg::OP_TOUCH;
                cmd.idx = chain_end.hit_idx;
              end
            end
          end
          bclf_pkg::REQ_MARK: begin
            emit = out_free;
            if (chain_end.found) begin
              e_kind = bclf_pkg::K_DSET;
              e_slot = chain_end.hit_idx;
              if (out_free) begin
                cmd.op  = bclf_pkg::OP_SET_DIRTY;
                cmd.idx = chain_end.hit_idx;
              end
            end else begin
              e_kind = bclf_pkg::K_NC;
            end
          end
          bclf_pkg::REQ_SYNC: begin
            if (!mounted) begin
              emit   = out_free;
              e_kind = bclf_pkg::K_SYNC;
            end
          end
          bclf_pkg::REQ_BAD: emit = out_free;
        endcase
      end
      S_EMIT_WB, S_EMIT_SWB: begin
        emit     = out_free;
        e_kind   = bclf_pkg::K_WB;
        e_slot   = vidx;
        e_lba    = lba_q;
        e_writes = wr_cnt + bclf_pkg::CNT_W'(1);
        e_last   = 1'b0;
        if (out_free && (state == S_EMIT_SWB)) begin
          cmd.op = bclf_pkg::OP_CLR_DIRTY;
        end
      end
      S_EMIT_FILL: begin
        emit     = out_free;
        age_step = out_free;
        e_kind   = fail_q ? bclf_pkg::K_FFAIL : bclf_pkg::K_FILL;
        e_slot   = vidx;
        e_lba    = lba_q;
        e_reads  = rd_cnt + bclf_pkg::CNT_W'(1);
        if (out_free) begin
          // A failed fill leaves the slot empty.
          cmd.op  = bclf_pkg::OP_FILL;
          cmd.tag = fail_q ? '0 : blk_q;
          cmd.age = fail_q ? '0 : age_inc;
        end
      end
      S_SYNC_FIND: begin
        if (!any_pend) begin
          emit      = out_free;
          e_kind    = bclf_pkg::K_SYNC;
          e_flushed = flushed;
        end
      end
      S_IDLE, S_SCAN, S_MUL_WB, S_MUL_FILL, S_MUL_SWB: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      spb         <= bclf_pkg::SPB_W'(2);
      mounted     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bclf_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data[bclf_pkg::TAG_W-1:0];
        bclf_pkg::CFG_SECTORS:     spb         <= cfg_data[bclf_pkg::SPB_W-1:0];
        bclf_pkg::CFG_MOUNTED:     mounted     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_q     <= bclf_pkg::REQ_GET;
      blk_q     <= '0;
      fail_q    <= 1'b0;
      cnt       <= '0;
      vidx      <= '0;
      vtag      <= '0;
      lba_q     <= '0;
      flushed   <= '0;
      age_clock <= '0;
      rd_cnt    <= '0;
      wr_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid   <= 1'b1;
        out_kind    <= e_kind;
        out_slot    <= bclf_pkg::SLOT_OUT_W'(e_slot);
        out_lba     <= e_lba;
        out_flushed <= bclf_pkg::FLUSH_OUT_W'(e_flushed);
        out_reads   <= e_reads;
        out_writes  <= e_writes;
        out_last    <= e_last;
        rd_cnt      <= e_reads;
        wr_cnt      <= e_writes;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (age_step) begin
        age_clock <= age_inc;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_q  <= bclf_pkg::req_t'(s_tuser);
            blk_q  <= s_tdata[bclf_pkg::TAG_W-1:0];
            fail_q <= s_tdata[bclf_pkg::TAG_W];
            cnt    <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Wait for the new block number to ripple through every cell.
          cnt <= cnt + bclf_pkg::SLOT_W'(1);
          if (cnt == bclf_pkg::SLOT_W'(bclf_pkg::SLOTS - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (emit) begin
            state <= S_IDLE;
          end else if (req_q == bclf_pkg::REQ_GET && !reject && !chain_end.found) begin
            vidx <= chain_end.best_idx;
            vtag <= chain_end.best_tag;
            if (chain_end.best_dirty && chain_end.best_tag != '0) begin
              state <= S_MUL_WB;
            end else begin
              state <= S_MUL_FILL;
            end
          end else if (req_q == bclf_pkg::REQ_SYNC && mounted) begin
            flushed <= '0;
            state   <= S_SYNC_FIND;
          end
        end
        S_MUL_WB: begin
          lba_q <= mul_full[bclf_pkg::LBA_W-1:0];
          state <= S_EMIT_WB;
        end
        S_EMIT_WB: begin
          if (emit) begin
            state <= S_MUL_FILL;
          end
        end
        S_MUL_FILL: begin
          lba_q <= mul_full[bclf_pkg::LBA_W-1:0];
          state <= S_EMIT_FILL;
        end
        S_EMIT_FILL: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        S_SYNC_FIND: begin
          if (any_pend) begin
            vidx  <= first;
            vtag  <= stat[first].tag;
            state <= S_MUL_SWB;
          end else if (emit) begin
            state <= S_IDLE;
          end
        end
        S_MUL_SWB: begin
          lba_q <= mul_full[bclf_pkg::LBA_W-1:0];
          state <= S_EMIT_SWB;
        end
        S_EMIT_SWB: begin
          if (emit) begin
            flushed <= flushed + bclf_pkg::FLUSH_W'(1);
            state   <= S_SYNC_FIND;
          end
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {out_writes, out_reads, out_flushed, out_lba, out_slot};

  // Valid tags are unique, so a lookup never hits two slots.
  `BCLF_ASSERT_IMP(a_single_hit, 1'b1, $onehot0(match_vec))
  // The write counter moves only when a writeback command is presented.
  `BCLF_ASSERT_IMP(a_wr_with_wb, wr_cnt != $past(wr_cnt),
                   m_tvalid && m_tuser == bclf_pkg::K_WB)
  // The age clock moves only on a hit, fill or failed-fill result.
  `BCLF_ASSERT_IMP(a_age_with_use, age_clock != $past(age_clock),
                   m_tvalid && (m_tuser == bclf_pkg::K_HIT || m_tuser == bclf_pkg::K_FILL ||
                                m_tuser == bclf_pkg::K_FFAIL))

endmodule

`default_nettype wire

// File: sv/bclf_cell.sv
// One directory slot: tag, age and dirty bit plus one stage of the search chain.
`default_nettype none

module bclf_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bclf_pkg::SLOT_W-1:0] cell_idx,
  input  logic [bclf_pkg::TAG_W-1:0]  blk,
  input  bclf_pkg::cell_cmd_t         cmd,
  input  bclf_pkg::chain_t            chain_in,
  output bclf_pkg::chain_t            chain_out,
  output bclf_pkg::cell_stat_t        stat
);

  logic [bclf_pkg::TAG_W-1:0] tag;
  logic [bclf_pkg::AGE_W-1:0] age;
  logic                       dirty;
  logic                       match;
  logic                       take;
  logic                       sel;
  bclf_pkg::chain_t           chain_next;

  always_comb begin
    match = (age != '0) && (tag == blk);
    sel   = (cmd.idx == cell_idx);
    // Clean beats dirty, then lower age; ties keep the earlier slot.
    if (!chain_in.have) begin
      take = 1'b1;
    end else if (dirty != chain_in.best_dirty) begin
      take = !dirty;
    end else begin
      take = (age < chain_in.best_age);
    end

    chain_next = chain_in;
    if (!chain_in.found && match) begin
      chain_next.found   = 1'b1;
      chain_next.hit_idx = cell_idx;
    end
    if (take) begin
      chain_next.have       = 1'b1;
      chain_next.best_idx   = cell_idx;
      chain_next.best_dirty = dirty;
      chain_next.best_age   = age;
      chain_next.best_tag   = tag;
    end

    stat.match = match;
    stat.flush = dirty && (tag != '0);
    stat.tag   = tag;
  end

  always_ff @(posedge clk) begin
    chain_out <= chain_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag   <= '0;
      age   <= '0;
      dirty <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        bclf_pkg::OP_FILL: begin
          tag   <= cmd.tag;
          age   <= cmd.age;
          dirty <= 1'b0;
        end
        bclf_pkg::OP_TOUCH:     age   <= cmd.age;
        bclf_pkg::OP_SET_DIRTY: dirty <= 1'b1;
        bclf_pkg::OP_CLR_DIRTY: dirty <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the clean-first LRU block cache directory: directed table, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bclf_pkg::*;

  localparam int MAX_QUIET    = 3000;
  localparam int DRAIN_PAUSE  = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int RESET_ROWS   = 6;
  localparam int TABLE_ROWS   = 22;
  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 70;

  typedef struct packed {
    kind_t                  kind;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [LBA_W-1:0]       lba;
    logic [FLUSH_OUT_W-1:0] flushed;
    logic [CNT_W-1:0]       reads;
    logic [CNT_W-1:0]       writes;
    logic                   last;
  } cache_result_t;

  typedef struct {
    req_t             req;
    logic [TAG_W-1:0] blk;
    logic             fails;
    bit               typed;
    cache_result_t    want;
  } stim_row_t;

  typedef struct {
    logic [CFG_W-1:0] blocks;
    logic [SPB_W-1:0] spb;
    logic             mounted;
    int               idle_pct;
    int               stall_pct;
    int               pool;
    bit               hold_off;
    bit               pause_midway;
  } phase_t;

  localparam cache_result_t NO_RESULT = '0;
  localparam cache_result_t REJ_AT_RESET = '{K_REJ, 4'd0, 39'd0, 5'd0, 32'd0, 32'd0, 1'b1};
  localparam cache_result_t NC_AT_RESET = '{K_NC, 4'd0, 39'd0, 5'd0, 32'd0, 32'd0, 1'b1};
  localparam cache_result_t SYNC_AT_RESET = '{K_SYNC, 4'd0, 39'd0, 5'd0, 32'd0, 32'd0, 1'b1};

  // First RESET_ROWS rows run with reset configuration, the rest with the widest volume.
  stim_row_t opening_rows [TABLE_ROWS] = '{
    '{REQ_GET,  32'd1,          1'b0, 1'b1, REJ_AT_RESET},
    '{REQ_GET,  32'hFFFF_FFFF,  1'b1, 1'b1, REJ_AT_RESET},
    '{REQ_GET,  32'd0,          1'b0, 1'b1, REJ_AT_RESET},
    '{REQ_MARK, 32'd0,          1'b0, 1'b1, NC_AT_RESET},
    '{REQ_SYNC, 32'h5555_5555,  1'b0, 1'b1, SYNC_AT_RESET},
    '{REQ_BAD,  32'hAAAA_AAAA,  1'b1, 1'b1, REJ_AT_RESET},
    '{REQ_GET,  32'hFFFF_FFFE,  1'b0, 1'b0, NO_RESULT},
    '{REQ_GET,  32'hFFFF_FFFF,  1'b0, 1'b0, NO_RESULT},
    '{REQ_GET,  32'd0,          1'b0, 1'b0, NO_RESULT},
    '{REQ_GET,  32'd1,          1'b1, 1'b0, NO_RESULT},
    '{REQ_GET,  32'd1,          1'b0, 1'b0, NO_RESULT},
    '{REQ_MARK, 32'd1,          1'b0, 1'b0, NO_RESULT},
    '{REQ_MARK, 32'hFFFF_FFFE,  1'b0, 1'b0, NO_RESULT},
    '{REQ_MARK, 32'd2,          1'b0, 1'b0, NO_RESULT},
    '{REQ_GET,  32'd1,          1'b0, 1'b0, NO_RESULT},
    '{REQ_GET,  32'd2,          1'b0, 1'b0, NO_RESULT},
    '{REQ_SYNC, 32'd0,          1'b0, 1'b0, NO_RESULT},
    '{REQ_MARK, 32'd2,          1'b0, 1'b0, NO_RESULT},
    '{REQ_BAD,  32'd0,          1'b0, 1'b0, NO_RESULT},
    '{REQ_GET,  32'd2,          1'b1, 1'b0, NO_RESULT},
    '{REQ_SYNC, 32'd0,          1'b1, 1'b0, NO_RESULT},
    '{REQ_SYNC, 32'd0,          1'b0, 1'b0, NO_RESULT}
  };

  phase_t phases [PHASES] = '{
    '{32'd21, 8'd2,   1'b1, 0,  0,  22, 1'b0, 1'b0},
    '{32'd20, 8'd128, 1'b0, 81, 0,  21, 1'b0, 1'b0},
    '{32'd30, 8'd127, 1'b1, 0,  81, 31, 1'b1, 1'b0},
    '{32'd19, 8'd3,   1'b1, 6,  6,  20, 1'b0, 1'b1}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [KIND_W-1:0]      m_tuser;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  block_cache_lru_clean_first DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Directory predictor state and its copy of the registers.
  logic [TAG_W-1:0] dir_tag   [SLOTS] = '{default: '0};
  logic [AGE_W-1:0] dir_age   [SLOTS] = '{default: '0};
  logic             dir_dirty [SLOTS] = '{default: 1'b0};
  logic [AGE_W-1:0] dir_clock = '0;
  logic [CNT_W-1:0] dir_reads = '0;
  logic [CNT_W-1:0] dir_writes = '0;
  logic [CFG_W-1:0] dir_blocks = '0;
  logic [SPB_W-1:0] dir_spb = 8'd2;
  logic             dir_mounted = 1'b0;

  cache_result_t fresh_results [$];
  cache_result_t expected_results [$];

  int errors = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_asks = 0;

  function automatic logic [LBA_W-1:0] sector_of(logic [TAG_W-1:0] blk);
    logic [63:0] prod;
    prod = 64'(blk) * 64'(dir_spb);
    return prod[LBA_W-1:0];
  endfunction

  function automatic void post(kind_t k, int slot, logic [LBA_W-1:0] lba, int flushed);
    cache_result_t r;
    r.kind    = k;
    r.slot    = SLOT_OUT_W'(slot);
    r.lba     = lba;
    r.flushed = FLUSH_OUT_W'(flushed);
    r.reads   = dir_reads;
    r.writes  = dir_writes;
    r.last    = 1'b0;
    fresh_results.push_back(r);
  endfunction

  function automatic int find_block(logic [TAG_W-1:0] blk);
    for (int i = 0; i < SLOTS; i++)
      if (dir_age[i] != 0 && dir_tag[i] == blk) return i;
    return -1;
  endfunction

  // Clean slots win over dirty ones, then the oldest, then the lowest index.
  function automatic int choose_victim();
    int best;
    best = 0;
    for (int i = 1; i < SLOTS; i++) begin
      if (dir_dirty[i] != dir_dirty[best]) begin
        if (!dir_dirty[i]) best = i;
      end else if (dir_age[i] < dir_age[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void apply_request(req_t req, logic [TAG_W-1:0] blk, logic fails);
    int idx;
    int flushed;
    fresh_results.delete();
    case (req)
      REQ_GET: begin
        if (blk == 0 || blk >= dir_blocks) begin
          post(K_REJ, 0, '0, 0);
        end else begin
          idx = find_block(blk);
          if (idx >= 0) begin
            dir_clock++;
            dir_age[idx] = dir_clock;
            post(K_HIT, idx, '0, 0);
          end else begin
            idx = choose_victim();
            if (dir_dirty[idx] && dir_tag[idx] != 0) begin
              dir_writes++;
              post(K_WB, idx, sector_of(dir_tag[idx]), 0);
            end
            dir_dirty[idx] = 1'b0;
            dir_tag[idx] = blk;
            dir_clock++;
            dir_age[idx] = dir_clock;
            dir_reads++;
            if (fails) begin
              dir_tag[idx] = '0;
              dir_age[idx] = '0;
              post(K_FFAIL, idx, sector_of(blk), 0);
            end else begin
              post(K_FILL, idx, sector_of(blk), 0);
            end
          end
        end
      end
      REQ_MARK: begin
        idx = find_block(blk);
        if (idx >= 0) begin
          dir_dirty[idx] = 1'b1;
          post(K_DSET, idx, '0, 0);
        end else begin
          post(K_NC, 0, '0, 0);
        end
      end
      REQ_SYNC: begin
        flushed = 0;
        if (dir_mounted) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (dir_dirty[i] && dir_tag[i] != 0) begin
              dir_writes++;
              dir_dirty[i] = 1'b0;
              flushed++;
              post(K_WB, i, sector_of(dir_tag[i]), 0);
            end
          end
        end
        post(K_SYNC, 0, '0, flushed);
      end
      default: post(K_REJ, 0, '0, 0);
    endcase
    fresh_results[fresh_results.size() - 1].last = 1'b1;
  endfunction

  // Offer one request; call and return at a falling edge.
  task automatic offer(req_t req, logic [TAG_W-1:0] blk, logic fails, bit typed,
                       cache_result_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - TAG_W - 1){1'b0}}, fails, blk};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    apply_request(req, blk, fails);
    if (typed) expected_results.push_back(want);
    else foreach (fresh_results[i]) expected_results.push_back(fresh_results[i]);
    @(negedge clk);
  endtask

  task automatic wait_drained(bit settle);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    if (settle) repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      CFG_BLOCK_COUNT: dir_blocks = value;
      CFG_SECTORS:     dir_spb = value[SPB_W-1:0];
      CFG_MOUNTED:     dir_mounted = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_volume(logic [CFG_W-1:0] blocks, logic [SPB_W-1:0] spb, logic mounted);
    write_reg(CFG_BLOCK_COUNT, blocks);
    write_reg(CFG_SECTORS, CFG_W'(spb));
    write_reg(CFG_MOUNTED, CFG_W'(mounted));
    cfg_we <= 1'b0;
  endtask

  // Mostly gets and marks over a small block pool so slots fill, dirty up and evict.
  task automatic random_traffic(int count, int pool, bit pause_midway);
    int r;
    logic [TAG_W-1:0] blk;
    bit paused;
    paused = 1'b0;
    for (int n = 0; n < count; n++) begin
      // a get plus mark pair can step over the midpoint, so test with >=
      if (pause_midway && !paused && n >= count / 2) begin
        wait_drained(1'b0);
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      blk = $urandom_range(1, pool);
      if (r < 45) begin
        offer(REQ_GET, blk, $urandom_range(0, 15) == 0, 1'b0, NO_RESULT);
        if ($urandom_range(0, 1)) begin
          offer(REQ_MARK, blk, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
          n++;
        end
      end else if (r < 75) begin
        offer(REQ_MARK, blk, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end else if (r < 82) begin
        offer(REQ_SYNC, $urandom, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end else if (r < 86) begin
        offer(REQ_BAD, $urandom, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end else if (r < 94) begin
        offer(REQ_GET, $urandom, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end else begin
        offer(REQ_MARK, $urandom, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end
    end
  endtask

  // Result receiver; a hold-off request holds m_tready low until hold_left runs down to zero.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind    = kind_t'(m_tuser);
      got.slot    = m_tdata[3:0];
      got.lba     = m_tdata[42:4];
      got.flushed = m_tdata[47:43];
      got.reads   = m_tdata[79:48];
      got.writes  = m_tdata[111:80];
      got.last    = m_tlast;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: kind %0d slot %0d lba %0h flushed %0d", got.kind,
                   got.slot, got.lba, got.flushed);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.lba !== want.lba ||
            got.flushed !== want.flushed || got.reads !== want.reads ||
            got.writes !== want.writes || got.last !== want.last) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("mismatch exp: kind %0d slot %0d lba %0h flushed %0d rd %0d wr %0d last %0d",
                     want.kind, want.slot, want.lba, want.flushed, want.reads, want.writes,
                     want.last);
            $display("         got: kind %0d slot %0d lba %0h flushed %0d rd %0d wr %0d last %0d",
                     got.kind, got.slot, got.lba, got.flushed, got.reads, got.writes,
                     got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= MAX_QUIET) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_volume(32'd0, 8'd2, 1'b0);

    for (int i = 0; i < TABLE_ROWS; i++) begin
      if (i == RESET_ROWS) begin
        wait_drained(1'b1);
        set_volume(32'hFFFF_FFFF, 8'd128, 1'b1);
      end
      offer(opening_rows[i].req, opening_rows[i].blk, opening_rows[i].fails,
            opening_rows[i].typed, opening_rows[i].want);
    end

    foreach (phases[p]) begin
      wait_drained(1'b1);
      set_volume(phases[p].blocks, phases[p].spb, phases[p].mounted);
      sender_idle_pct = phases[p].idle_pct;
      rx_stall_pct = phases[p].stall_pct;
      // hold results back while requests keep coming so the input side backs up
      if (phases[p].hold_off) hold_asks++;
      random_traffic(PHASE_ITEMS, phases[p].pool, phases[p].pause_midway);
    end

    wait_drained(1'b1);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/bclf_pkg.sv
sv/bclf_cell.sv
sv/block_cache_lru_clean_first.sv
tb/tb.sv
